@@ hdl/aouc_pkg.sv @@
// Shared types and constants for the alpha over/under compositor.
package aouc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CHAN_W     = 8;
    localparam int FACTOR_W   = 9;
    localparam int ROW_W      = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_EVEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_ODD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd3;

    localparam logic MODE_OVER  = 1'b0;
    localparam logic MODE_UNDER = 1'b1;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 9'd256;
    localparam logic [ROW_W-1:0]    ROW_WIDTH_RESET = 13'd1920;

    typedef struct packed {
        logic load_in;
        logic step1;
        logic step2;
        logic load_out;
    } aouc_cmd_t;

endpackage

@@ hdl/aouc_ctrl.sv @@
// Sequencing controller: handshakes and stage commands for the compositor datapath.
module aouc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output aouc_pkg::aouc_cmd_t cmd
);
    import aouc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.step1  = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.step2  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_in, cmd.step1, cmd.step2, cmd.load_out}))
        else $error("more than one stage command at once");

    a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd.step1 ##1 cmd.step2)
        else $error("stage sequence broken after accepted transaction");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.load_out)
        else $error("output register overwritten before its transaction");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step1 || cmd.step2) |-> !in_ready)
        else $error("input accepted while datapath busy");
`endif

endmodule

@@ hdl/aouc_dp.sv @@
// Compositor datapath: configuration, row tracking, multiplier stages and output register.
module aouc_dp #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  aouc_pkg::aouc_cmd_t                  cmd,
    input  logic                                 cfg_write,
    input  logic [aouc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [aouc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 frame_start,
    input  logic [7:0]                           fg_red,
    input  logic [7:0]                           fg_green,
    input  logic [7:0]                           fg_blue,
    input  logic [7:0]                           fg_alpha,
    input  logic [7:0]                           bg_red,
    input  logic [7:0]                           bg_green,
    input  logic [7:0]                           bg_blue,
    input  logic [7:0]                           bg_alpha,
    output logic [7:0]                           out_red,
    output logic [7:0]                           out_green,
    output logic [7:0]                           out_blue,
    output logic [7:0]                           out_alpha
);
    import aouc_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROW_WIDTH);
    localparam int CMP_W = (CNT_W + 1 > ROW_W) ? CNT_W + 1 : ROW_W;
    localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_ROW_WIDTH);

    localparam logic [1:0] SEL_BLEND = 2'd0;
    localparam logic [1:0] SEL_FG    = 2'd1;
    localparam logic [1:0] SEL_BG    = 2'd2;

    // configuration
    logic                mode_cfg_reg;
    logic [FACTOR_W-1:0] factor_even_reg;
    logic [FACTOR_W-1:0] factor_odd_reg;
    logic [ROW_W-1:0]    row_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg    <= MODE_OVER;
            factor_even_reg <= FACTOR_ONE;
            factor_odd_reg  <= FACTOR_ONE;
            row_width_reg   <= ROW_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_BLEND_MODE:  mode_cfg_reg    <= cfg_data[0];
                REG_FACTOR_EVEN: factor_even_reg <= cfg_data[FACTOR_W-1:0];
                REG_FACTOR_ODD:  factor_odd_reg  <= cfg_data[FACTOR_W-1:0];
                REG_ROW_WIDTH:   row_width_reg   <= cfg_data[ROW_W-1:0];
            endcase
        end
    end

    // row tracking
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic             odd_reg;
    logic             odd_next;
    logic [CNT_W-1:0] col_base;
    logic             par_base;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] rw_ext;
    logic [CMP_W-1:0] eff_w;

    always_comb
    begin
        col_base = frame_start ? '0 : col_reg;
        par_base = frame_start ? 1'b0 : odd_reg;
        col_inc  = CMP_W'(col_base) + CMP_W'(1);
        rw_ext   = CMP_W'(row_width_reg);
        priority if (rw_ext == '0)
            eff_w = CMP_W'(1);
        else if (rw_ext > MAX_W)
            eff_w = MAX_W;
        else
            eff_w = rw_ext;
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            odd_next = ~par_base;
        end
        else
        begin
            col_next = col_inc[CNT_W-1:0];
            odd_next = par_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            odd_reg <= 1'b0;
        end
        else if (cmd.load_in)
        begin
            col_reg <= col_next;
            odd_reg <= odd_next;
        end
    end

    // input capture
    logic [FACTOR_W-1:0] f_raw;
    logic [FACTOR_W-1:0] f_reg;
    logic                mode_reg;
    logic [7:0]          fg_reg [4];
    logic [7:0]          bg_reg [4];

    assign f_raw = par_base ? factor_odd_reg : factor_even_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            f_reg     <= (f_raw > FACTOR_ONE) ? FACTOR_ONE : f_raw;
            mode_reg  <= mode_cfg_reg;
            fg_reg[0] <= fg_red;
            fg_reg[1] <= fg_green;
            fg_reg[2] <= fg_blue;
            fg_reg[3] <= fg_alpha;
            bg_reg[0] <= bg_red;
            bg_reg[1] <= bg_green;
            bg_reg[2] <= bg_blue;
            bg_reg[3] <= bg_alpha;
        end
    end

    // stage 1: factor against alpha
    logic [FACTOR_W-1:0]   alpha_op;
    logic [2*FACTOR_W-1:0] prod1_reg;

    assign alpha_op = (mode_reg == MODE_UNDER) ? (FACTOR_ONE - FACTOR_W'(bg_reg[3]))
                                               : FACTOR_W'(fg_reg[3]);

    always_ff @(posedge clk)
    begin
        if (cmd.step1)
            prod1_reg <= (2*FACTOR_W)'(f_reg) * (2*FACTOR_W)'(alpha_op);
    end

    // stage 2: channel weights and bypass decision
    logic [FACTOR_W-1:0] p_hi;
    logic [FACTOR_W-1:0] m_val;
    logic [FACTOR_W-1:0] coef_fg;
    logic [FACTOR_W-1:0] coef_bg;
    logic [1:0]          sel;
    logic [1:0]          sel_reg;
    logic [16:0]         pfg_reg [4];
    logic [16:0]         pbg_reg [4];

    always_comb
    begin
        p_hi  = prod1_reg[2*FACTOR_W-2:8];
        m_val = FACTOR_ONE - p_hi;
        if (mode_reg == MODE_UNDER)
        begin
            coef_fg = p_hi;
            coef_bg = FACTOR_W'(bg_reg[3]);
            priority if (bg_reg[3] == 8'd0 && f_reg == FACTOR_ONE)
                sel = SEL_FG;
            else if (bg_reg[3] == 8'd255)
                sel = SEL_BG;
            else if (p_hi == '0)
                sel = SEL_BG;
            else
                sel = SEL_BLEND;
        end
        else
        begin
            coef_fg = f_reg;
            coef_bg = m_val;
            priority if (f_reg == '0)
                sel = SEL_BG;
            else if (m_val == '0)
                sel = SEL_FG;
            else
                sel = SEL_BLEND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step2)
        begin
            sel_reg <= sel;
            for (int i = 0; i < 4; i++)
            begin
                pfg_reg[i] <= 17'(coef_fg) * 17'(fg_reg[i]);
                pbg_reg[i] <= 17'(coef_bg) * 17'(bg_reg[i]);
            end
        end
    end

    // stage 3: sum, saturate, select
    logic [17:0] sum   [4];
    logic [7:0]  blend [4];
    logic [7:0]  res   [4];
    logic [7:0]  out_reg [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sum[i]   = 18'(pfg_reg[i]) + 18'(pbg_reg[i]);
            blend[i] = (|sum[i][17:16]) ? 8'd255 : sum[i][15:8];
            unique case (sel_reg)
                SEL_FG:  res[i] = fg_reg[i];
                SEL_BG:  res[i] = bg_reg[i];
                default: res[i] = blend[i];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            for (int i = 0; i < 4; i++)
                out_reg[i] <= res[i];
        end
    end

    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
    assign out_alpha = out_reg[3];

endmodule

@@ hdl/alpha_over_under_composite.sv @@
// The controller walks each accepted pixel in turn through the two multiplier
// stages (MUL1, MUL2) and the output stage (FIN), which waits until the output
// register is free; out_valid rises once FIN loads it, and in_ready stays low until then.
// A new pixel is taken while the previous result still waits at the output.
// Reset (rst_n low, asynchronous): controller idle, no result pending, column
// 0 and even row, blend_mode over, both factors 256, row_width 1920.
module alpha_over_under_composite #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [aouc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [aouc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            frame_start,
    input  logic [7:0]                      fg_red,
    input  logic [7:0]                      fg_green,
    input  logic [7:0]                      fg_blue,
    input  logic [7:0]                      fg_alpha,
    input  logic [7:0]                      bg_red,
    input  logic [7:0]                      bg_green,
    input  logic [7:0]                      bg_blue,
    input  logic [7:0]                      bg_alpha,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_red,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_blue,
    output logic [7:0]                      out_alpha
);
    import aouc_pkg::*;

    aouc_cmd_t cmd;

    aouc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    aouc_dp #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_write   (cfg_write),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .frame_start (frame_start),
        .fg_red      (fg_red),
        .fg_green    (fg_green),
        .fg_blue     (fg_blue),
        .fg_alpha    (fg_alpha),
        .bg_red      (bg_red),
        .bg_green    (bg_green),
        .bg_blue     (bg_blue),
        .bg_alpha    (bg_alpha),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha)
    );

endmodule
